@@ hw/rtl/tql_pkg.sv @@
// tql_pkg: shared sizes, register codes and control structures for the q-learning agent
// used by tql_ctrl, tql_datapath and tabular_q_learning_agent; no dependencies
`timescale 1ns / 1ps

package tql_pkg;

    // table geometry (powers of two)
    localparam int STATE_COUNT = 4096;
    localparam int MAX_ACTIONS = 16;
    localparam int VALUE_BITS  = 32;

    localparam int STATE_BITS  = $clog2(STATE_COUNT);
    localparam int ACTION_BITS = $clog2(MAX_ACTIONS);
    localparam int ADDR_W      = STATE_BITS + ACTION_BITS;
    localparam int DEPTH       = STATE_COUNT * MAX_ACTIONS;
    // wide enough to hold MAX_ACTIONS itself
    localparam int CNT_W       = ACTION_BITS + 1;

    // fixed field widths
    localparam int STATE_IN_W  = 12;
    localparam int ACT_IN_W    = 4;
    localparam int REWARD_W    = 32;
    localparam int CHANCE_W    = 16;
    localparam int PICK_W      = 16;
    localparam int OUT_ACT_W   = 4;
    localparam int OUT_VALUE_W = 32;
    localparam int MOD_CNT_W   = $clog2(PICK_W);

    // configuration port
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int ACT_REG_W   = 5;
    localparam int FRAC_W      = 17;
    localparam int FRAC_SHIFT  = 16;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIONS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 2'd3;

    localparam logic [ACT_REG_W-1:0] ACTIONS_RESET  = 5'd4;
    localparam logic [FRAC_W-1:0]    EXPLORE_RESET  = 17'd65536;
    localparam logic [FRAC_W-1:0]    LEARN_RESET    = 17'd6554;
    localparam logic [FRAC_W-1:0]    DISCOUNT_RESET = 17'd58982;

    // arithmetic widths
    localparam int GM_W   = VALUE_BITS + 2;
    localparam int DIFF_W = ((GM_W > REWARD_W) ? GM_W : REWARD_W) + 2;
    localparam int P1_W   = VALUE_BITS + FRAC_W + 1;
    localparam int P2_W   = DIFF_W + FRAC_W + 1;
    localparam int NV_W   = DIFF_W + 2;

    typedef struct packed {
        logic [CNT_W-1:0]  n_act;
        logic [FRAC_W-1:0] explore_rate;
        logic [FRAC_W-1:0] alpha;
        logic [FRAC_W-1:0] gamma;
    } cfg_t;

    typedef struct packed {
        logic                       mode;
        logic [STATE_IN_W-1:0]      state_index;
        logic [ACT_IN_W-1:0]        taken_action;
        logic signed [REWARD_W-1:0] reward;
        logic [STATE_IN_W-1:0]      reached_state;
        logic [CHANCE_W-1:0]        chance;
        logic [PICK_W-1:0]          random_pick;
    } item_t;

    typedef struct packed {
        logic load;
        logic clear_wr;
        logic scan_rd;
        logic rd_q;
        logic mul1;
        logic cap_q;
        logic sum;
        logic mul2;
        logic sat;
        logic write_q;
        logic mod_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic explore;
        logic scan_last;
        logic mod_last;
        logic clr_last;
    } status_t;

endpackage

@@ hw/rtl/tql_datapath.sv @@
// tql_datapath: value table memory, row scan, modulo unit and update arithmetic
// depends on tql_pkg; driven by tql_ctrl through cmd_t and status_t
`timescale 1ns / 1ps

module tql_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tql_pkg::cmd_t                 cmd,
    input  tql_pkg::cfg_t                 cfg,
    input  tql_pkg::item_t                item,
    output tql_pkg::status_t              status,
    output logic [tql_pkg::OUT_ACT_W-1:0] out_action,
    output logic                          out_explored,
    output logic [tql_pkg::OUT_VALUE_W-1:0] out_value
);
    import tql_pkg::*;

    localparam logic signed [NV_W-1:0] V_MAX =
        {{(NV_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [NV_W-1:0] V_MIN =
        {{(NV_W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

    logic signed [VALUE_BITS-1:0] mem [DEPTH];

    // captured item
    logic                          mode_reg;
    logic [STATE_BITS-1:0]         st_reg;
    logic [ACTION_BITS-1:0]        act_reg;
    logic signed [REWARD_W-1:0]    reward_reg;
    logic [STATE_BITS-1:0]         nx_reg;
    logic [CHANCE_W-1:0]           chance_reg;

    // control registers
    logic [ADDR_W-1:0]             clr_addr_reg;
    logic [ACTION_BITS-1:0]        scan_idx_reg;
    logic                          cmp_valid_reg;
    logic [MOD_CNT_W-1:0]          mod_cnt_reg;

    // payload registers
    logic [ACTION_BITS-1:0]        cmp_idx_reg;
    logic signed [VALUE_BITS-1:0]  rd_data_reg;
    logic signed [VALUE_BITS-1:0]  best_reg;
    logic [ACTION_BITS-1:0]        pick_reg;
    logic [PICK_W-1:0]             pick_sh_reg;
    logic [CNT_W-1:0]              rem_reg;
    logic signed [P1_W-1:0]        prod1_reg;
    logic signed [VALUE_BITS-1:0]  q_reg;
    logic signed [DIFF_W-1:0]      diff_reg;
    logic signed [P2_W-1:0]        prod2_reg;
    logic signed [VALUE_BITS-1:0]  nv_reg;
    logic [OUT_ACT_W-1:0]          out_action_reg;
    logic                          out_explored_reg;
    logic [OUT_VALUE_W-1:0]        out_value_reg;

    logic [STATE_BITS-1:0]         row;
    logic [ADDR_W-1:0]             q_addr;
    logic [ADDR_W-1:0]             rd_addr;
    logic [ADDR_W-1:0]             wr_addr;
    logic                          wr_en;
    logic signed [VALUE_BITS-1:0]  wr_data;
    logic [CNT_W:0]                mod_trial;
    logic [CNT_W-1:0]              rem_next;
    logic signed [P1_W-1:0]        gm_full;
    logic signed [GM_W-1:0]        gm;
    logic signed [P2_W-1:0]        term_full;
    logic signed [NV_W-1:0]        nv_wide;
    logic signed [VALUE_BITS-1:0]  nv_sat;

    always_comb
    begin
        row     = mode_reg ? nx_reg : st_reg;
        q_addr  = {st_reg, act_reg};
        rd_addr = cmd.rd_q ? q_addr : {row, scan_idx_reg};
        wr_en   = cmd.clear_wr | cmd.write_q;
        wr_addr = cmd.clear_wr ? clr_addr_reg : q_addr;
        wr_data = cmd.clear_wr ? '0 : nv_reg;
    end

    // one restoring step of random_pick modulo n_act
    always_comb
    begin
        mod_trial = {rem_reg, pick_sh_reg[PICK_W-1]};
        if (mod_trial >= {1'b0, cfg.n_act})
        begin
            rem_next = CNT_W'(mod_trial - {1'b0, cfg.n_act});
        end
        else
        begin
            rem_next = CNT_W'(mod_trial);
        end
    end

    // floor shifts of the two fraction products, then saturation
    always_comb
    begin
        gm_full   = prod1_reg >>> FRAC_SHIFT;
        gm        = GM_W'(gm_full);
        term_full = prod2_reg >>> FRAC_SHIFT;
        nv_wide   = NV_W'(q_reg) + NV_W'(term_full);
        priority if (nv_wide > V_MAX)
        begin
            nv_sat = VALUE_BITS'(V_MAX);
        end
        else if (nv_wide < V_MIN)
        begin
            nv_sat = VALUE_BITS'(V_MIN);
        end
        else
        begin
            nv_sat = VALUE_BITS'(nv_wide);
        end
    end

    always_comb
    begin
        status.mode      = mode_reg;
        status.explore   = {1'b0, chance_reg} < cfg.explore_rate;
        status.scan_last = CNT_W'(scan_idx_reg) == (cfg.n_act - CNT_W'(1));
        status.mod_last  = mod_cnt_reg == MOD_CNT_W'(PICK_W - 1);
        status.clr_last  = &clr_addr_reg;
    end

    // table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            mod_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                mod_cnt_reg  <= '0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_idx_reg <= scan_idx_reg + ACTION_BITS'(1);
                end
                if (cmd.mod_step)
                begin
                    mod_cnt_reg <= mod_cnt_reg + MOD_CNT_W'(1);
                end
            end
            cmp_valid_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= item.mode;
            st_reg      <= STATE_BITS'(item.state_index);
            act_reg     <= ACTION_BITS'(item.taken_action);
            reward_reg  <= item.reward;
            nx_reg      <= STATE_BITS'(item.reached_state);
            chance_reg  <= item.chance;
            pick_sh_reg <= item.random_pick;
            rem_reg     <= '0;
        end
        else if (cmd.mod_step)
        begin
            pick_sh_reg <= pick_sh_reg << 1;
            rem_reg     <= rem_next;
        end

        if (cmd.scan_rd)
        begin
            cmp_idx_reg <= scan_idx_reg;
        end

        // first entry seeds the maximum, later ones win only when strictly greater
        if (cmp_valid_reg)
        begin
            if ((cmp_idx_reg == '0) || (rd_data_reg > best_reg))
            begin
                best_reg <= rd_data_reg;
                pick_reg <= cmp_idx_reg;
            end
        end

        if (cmd.mul1)
        begin
            prod1_reg <= P1_W'(best_reg) * P1_W'($signed({1'b0, cfg.gamma}));
        end
        if (cmd.cap_q)
        begin
            q_reg <= rd_data_reg;
        end
        if (cmd.sum)
        begin
            diff_reg <= DIFF_W'(reward_reg) + DIFF_W'(gm) - DIFF_W'(q_reg);
        end
        if (cmd.mul2)
        begin
            prod2_reg <= P2_W'(diff_reg) * P2_W'($signed({1'b0, cfg.alpha}));
        end
        if (cmd.sat)
        begin
            nv_reg <= nv_sat;
        end

        if (cmd.out_load)
        begin
            if (mode_reg)
            begin
                out_action_reg   <= '0;
                out_explored_reg <= 1'b0;
                out_value_reg    <= OUT_VALUE_W'(nv_reg);
            end
            else if (status.explore)
            begin
                out_action_reg   <= OUT_ACT_W'(rem_reg);
                out_explored_reg <= 1'b1;
                out_value_reg    <= '0;
            end
            else
            begin
                out_action_reg   <= OUT_ACT_W'(pick_reg);
                out_explored_reg <= 1'b0;
                out_value_reg    <= '0;
            end
        end
    end

    assign out_action   = out_action_reg;
    assign out_explored = out_explored_reg;
    assign out_value    = out_value_reg;

endmodule

@@ hw/rtl/tql_ctrl.sv @@
// tql_ctrl: sequencing state machine for the q-learning agent
// depends on tql_pkg; issues cmd_t to tql_datapath and reads back status_t
`timescale 1ns / 1ps

module tql_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  tql_pkg::status_t status,
    output tql_pkg::cmd_t    cmd
);
    import tql_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_MOD,
        S_SCAN,
        S_SCAN_WAIT,
        S_READ_Q,
        S_Q_WAIT,
        S_SUM,
        S_MUL2,
        S_SAT,
        S_WRITE,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!status.mode && status.explore)
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                // last entry of the row is compared in this cycle
                state_next = status.mode ? S_READ_Q : S_OUT;
            end
            S_READ_Q:
            begin
                cmd.rd_q   = 1'b1;
                cmd.mul1   = 1'b1;
                state_next = S_Q_WAIT;
            end
            S_Q_WAIT:
            begin
                cmd.cap_q  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_q = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/tabular_q_learning_agent.sv @@
// Tabular Q-learning agent with an epsilon-greedy policy over a Q16.16 value table
// of STATE_COUNT x MAX_ACTIONS entries. After reset the table is swept to zero, one
// entry a cycle; no item is taken until that ends, while configuration writes are
// accepted throughout. One item is worked at a time and each gives exactly one
// result. A choose item that explores runs a bit-serial modulo of random_pick. A
// greedy choose item scans its row one memory read per cycle. An update scans the
// next-state row the same way, then reads the old value, does two multiplies and a
// saturating add and writes back. The single-port read of the table sets the scan
// length. A finished result sits in an output register, so the next item is accepted
// while it waits. Configuration registers must be written only while idle.
// depends on tql_pkg, tql_ctrl and tql_datapath
`timescale 1ns / 1ps

module tabular_q_learning_agent (
    input  logic                              clk,
    input  logic                              rst_n,
    // state_index[11:0], taken_action[15:12], reward[47:16], reached_state[59:48],
    // chance[75:60], random_pick[91:76], zero pad[95:92]
    input  logic [95:0]                       s_axis_tdata,
    // mode
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // chosen_action[3:0], new_value[35:4], zero pad[39:36]
    output logic [39:0]                       m_axis_tdata,
    // explored
    output logic                              m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [tql_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tql_pkg::CFG_W-1:0]         cfg_data
);
    import tql_pkg::*;

    localparam int CMP_W = (CNT_W > ACT_REG_W) ? CNT_W : ACT_REG_W;

    logic [ACT_REG_W-1:0] actions_in_use_reg;
    logic [FRAC_W-1:0]    explore_rate_reg;
    logic [FRAC_W-1:0]    learn_rate_reg;
    logic [FRAC_W-1:0]    discount_reg;

    logic [CMP_W-1:0]     act_wide;
    cfg_t                 cfg;
    item_t                item;
    cmd_t                 cmd;
    status_t              status;
    logic [OUT_ACT_W-1:0]   out_action;
    logic                   out_explored;
    logic [OUT_VALUE_W-1:0] out_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            actions_in_use_reg <= ACTIONS_RESET;
            explore_rate_reg   <= EXPLORE_RESET;
            learn_rate_reg     <= LEARN_RESET;
            discount_reg       <= DISCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIONS:  actions_in_use_reg <= ACT_REG_W'(cfg_data);
                REG_EXPLORE:  explore_rate_reg   <= FRAC_W'(cfg_data);
                REG_LEARN:    learn_rate_reg     <= FRAC_W'(cfg_data);
                REG_DISCOUNT: discount_reg       <= FRAC_W'(cfg_data);
            endcase
        end
    end

    // zero actions counts as one, more than MAX_ACTIONS counts as MAX_ACTIONS, fractions above one count as one
    always_comb
    begin
        act_wide = CMP_W'(actions_in_use_reg);
        priority if (act_wide == '0)
        begin
            cfg.n_act = CNT_W'(1);
        end
        else if (act_wide > CMP_W'(MAX_ACTIONS))
        begin
            cfg.n_act = CNT_W'(MAX_ACTIONS);
        end
        else
        begin
            cfg.n_act = CNT_W'(act_wide);
        end
        cfg.explore_rate = explore_rate_reg;
        cfg.alpha        = (learn_rate_reg > FRAC_ONE) ? FRAC_ONE : learn_rate_reg;
        cfg.gamma        = (discount_reg > FRAC_ONE) ? FRAC_ONE : discount_reg;
    end

    always_comb
    begin
        item.mode          = s_axis_tuser;
        item.state_index   = s_axis_tdata[11:0];
        item.taken_action  = s_axis_tdata[15:12];
        item.reward        = $signed(s_axis_tdata[47:16]);
        item.reached_state = s_axis_tdata[59:48];
        item.chance        = s_axis_tdata[75:60];
        item.random_pick   = s_axis_tdata[91:76];
    end

    tql_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tql_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .item         (item),
        .status       (status),
        .out_action   (out_action),
        .out_explored (out_explored),
        .out_value    (out_value)
    );

    assign m_axis_tdata = {4'b0000, out_value, out_action};
    assign m_axis_tuser = out_explored;

endmodule
